// ===== src/qsnb_pkg.sv =====
// ----------------------------------------------------------------------------
// qsnb_pkg
// Shared types, widths and codes of the quad setup pipeline.
// ----------------------------------------------------------------------------
package qsnb_pkg;

  // fixed point format of the vertex coordinates
  localparam int COORD_W     = 24;
  localparam int FRAC_BITS   = 8;
  localparam int CLIP_W      = 14;
  localparam int IMAGE_LIMIT = 8192;
  localparam int TOL_SHIFT   = 20;

  // datapath widths
  localparam int DIFF_W   = COORD_W + 1;         // vertex difference
  localparam int PROD_W   = 2 * DIFF_W;          // product of two differences
  localparam int SQ_W     = PROD_W + 1;          // squared edge length
  localparam int ORV_W    = PROD_W + 1;          // triangle orientation
  localparam int CORNER_W = ORV_W + 1;           // orientation, sign applied
  localparam int REL_W    = COORD_W + 3;         // offset from centroid, times 4
  localparam int RPROD_W  = 2 * REL_W;
  localparam int RSUM_W   = RPROD_W + 1;
  localparam int PX_W     = COORD_W - FRAC_BITS + 1;  // pixel coordinate
  localparam int CMP_W    = PX_W + 1;

  localparam int NUM_STAGES = 7;
  localparam int NUM_PAIRS  = 6;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic        [SQ_W-1:0]     sq_t;
  typedef logic signed [ORV_W-1:0]    orv_t;
  typedef logic signed [CORNER_W-1:0] corner_t;
  typedef logic signed [REL_W-1:0]    rel_t;
  typedef logic signed [RPROD_W-1:0]  rprod_t;
  typedef logic signed [RSUM_W-1:0]   rsum_t;
  typedef logic        [RSUM_W-1:0]   dsq_t;
  typedef logic        [CLIP_W-1:0]   clip_t;
  typedef logic        [1:0]          vidx_t;
  typedef logic        [2:0]          pidx_t;

  // one load enable per pipeline stage
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // vertex pairs (low index, high index)
  localparam vidx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam vidx_t PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // geometry class codes
  localparam logic [1:0] CLS_CONVEX      = 2'd0;
  localparam logic [1:0] CLS_REORDERED   = 2'd1;
  localparam logic [1:0] CLS_UNSUPPORTED = 2'd2;

  // angle classes around the centroid, in sort order
  localparam logic [1:0] ANG_BELOW = 2'd0;
  localparam logic [1:0] ANG_ZERO  = 2'd1;
  localparam logic [1:0] ANG_ABOVE = 2'd2;
  localparam logic [1:0] ANG_PI    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd3;

  // pair index of two distinct vertices, either order
  function automatic pidx_t pair_idx(input vidx_t a, input vidx_t b);
    logic [3:0] key;
    pidx_t      r;
    key = (a < b) ? {a, b} : {b, a};
    unique case (key)
      4'b0001: r = 3'd0;
      4'b0010: r = 3'd1;
      4'b0011: r = 3'd2;
      4'b0110: r = 3'd3;
      4'b0111: r = 3'd4;
      4'b1011: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/qsnb_geom.sv =====
// ----------------------------------------------------------------------------
// qsnb_geom
// Stages 1 to 3: vertex differences, products and sums for the convexity
// test and the angular sort.
// ----------------------------------------------------------------------------
module qsnb_geom (
  input  logic                clk,
  input  qsnb_pkg::stage_en_t en,
  input  qsnb_pkg::coord_t    x    [4],
  input  qsnb_pkg::coord_t    y    [4],
  output qsnb_pkg::sq_t       sq   [qsnb_pkg::NUM_PAIRS],
  output qsnb_pkg::orv_t      orv  [4],
  output qsnb_pkg::rsum_t     cp   [qsnb_pkg::NUM_PAIRS],
  output qsnb_pkg::dsq_t      dsq  [4],
  output logic [1:0]          acls [4]
);

  // orientation of the triangle missing vertex m: pair (a,b) and pair (a,p)
  localparam qsnb_pkg::pidx_t OR_AB [4] = '{3'd3, 3'd1, 3'd0, 3'd0};
  localparam qsnb_pkg::pidx_t OR_AP [4] = '{3'd4, 3'd2, 3'd2, 3'd1};

  localparam int SUM_W = qsnb_pkg::COORD_W + 2;

  qsnb_pkg::diff_t  dxp [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::diff_t  dyp [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::rel_t   rx  [4];
  qsnb_pkg::rel_t   ry  [4];
  qsnb_pkg::rel_t   rx_next [4];
  qsnb_pkg::rel_t   ry_next [4];
  logic [1:0]       acls1 [4];
  logic [1:0]       acls2 [4];
  logic [1:0]       acls_next [4];

  qsnb_pkg::prod_t  sqa [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::prod_t  sqb [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::prod_t  ora [4];
  qsnb_pkg::prod_t  orb [4];
  qsnb_pkg::rprod_t cpa [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::rprod_t cpb [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::rprod_t dsa [4];
  qsnb_pkg::rprod_t dsb [4];

  // centroid offsets (scaled by 4) and their angle classes
  always_comb begin
    logic signed [SUM_W-1:0] sumx;
    logic signed [SUM_W-1:0] sumy;
    sumx = '0;
    sumy = '0;
    for (int i = 0; i < 4; i++) begin
      sumx = sumx + SUM_W'(x[i]);
      sumy = sumy + SUM_W'(y[i]);
    end
    for (int i = 0; i < 4; i++) begin
      rx_next[i] = (qsnb_pkg::REL_W'(x[i]) <<< 2) - qsnb_pkg::REL_W'(sumx);
      ry_next[i] = (qsnb_pkg::REL_W'(y[i]) <<< 2) - qsnb_pkg::REL_W'(sumy);
      if (ry_next[i] < 0) begin
        acls_next[i] = qsnb_pkg::ANG_BELOW;
      end else if (ry_next[i] > 0) begin
        acls_next[i] = qsnb_pkg::ANG_ABOVE;
      end else if (rx_next[i] < 0) begin
        acls_next[i] = qsnb_pkg::ANG_PI;
      end else begin
        acls_next[i] = qsnb_pkg::ANG_ZERO;
      end
    end
  end

  // stage 1: differences and offsets
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int p = 0; p < qsnb_pkg::NUM_PAIRS; p++) begin
        dxp[p] <= qsnb_pkg::DIFF_W'(x[qsnb_pkg::PAIR_B[p]])
                - qsnb_pkg::DIFF_W'(x[qsnb_pkg::PAIR_A[p]]);
        dyp[p] <= qsnb_pkg::DIFF_W'(y[qsnb_pkg::PAIR_B[p]])
                - qsnb_pkg::DIFF_W'(y[qsnb_pkg::PAIR_A[p]]);
      end
      rx    <= rx_next;
      ry    <= ry_next;
      acls1 <= acls_next;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int p = 0; p < qsnb_pkg::NUM_PAIRS; p++) begin
        sqa[p] <= dxp[p] * dxp[p];
        sqb[p] <= dyp[p] * dyp[p];
        cpa[p] <= rx[qsnb_pkg::PAIR_A[p]] * ry[qsnb_pkg::PAIR_B[p]];
        cpb[p] <= ry[qsnb_pkg::PAIR_A[p]] * rx[qsnb_pkg::PAIR_B[p]];
      end
      for (int m = 0; m < 4; m++) begin
        ora[m] <= dxp[OR_AB[m]] * dyp[OR_AP[m]];
        orb[m] <= dyp[OR_AB[m]] * dxp[OR_AP[m]];
        dsa[m] <= rx[m] * rx[m];
        dsb[m] <= ry[m] * ry[m];
      end
      acls2 <= acls1;
    end
  end

  // stage 3: sums and differences of products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int p = 0; p < qsnb_pkg::NUM_PAIRS; p++) begin
        sq[p] <= {1'b0, sqa[p]} + {1'b0, sqb[p]};
        cp[p] <= qsnb_pkg::RSUM_W'(cpa[p]) - qsnb_pkg::RSUM_W'(cpb[p]);
      end
      for (int m = 0; m < 4; m++) begin
        orv[m] <= qsnb_pkg::ORV_W'(ora[m]) - qsnb_pkg::ORV_W'(orb[m]);
        dsq[m] <= {1'b0, dsa[m]} + {1'b0, dsb[m]};
      end
      acls <= acls2;
    end
  end

endmodule

// ===== src/qsnb_classify.sv =====
// ----------------------------------------------------------------------------
// qsnb_classify
// Stages 4 to 7: convexity test as given, angular sort by rank, convexity
// test of the sorted order, class and vertex order.
// ----------------------------------------------------------------------------
module qsnb_classify (
  input  logic                clk,
  input  qsnb_pkg::stage_en_t en,
  input  qsnb_pkg::sq_t       sq   [qsnb_pkg::NUM_PAIRS],
  input  qsnb_pkg::orv_t      orv  [4],
  input  qsnb_pkg::rsum_t     cp   [qsnb_pkg::NUM_PAIRS],
  input  qsnb_pkg::dsq_t      dsq  [4],
  input  logic [1:0]          acls [4],
  output logic [1:0]          geometry_class,
  output qsnb_pkg::vidx_t     order [4]
);

  function automatic qsnb_pkg::sq_t max2(input qsnb_pkg::sq_t a, input qsnb_pkg::sq_t b);
    return (a > b) ? a : b;
  endfunction

  // no corner beyond tolerance on both sides
  function automatic logic signs_agree(input qsnb_pkg::corner_t c [4],
                                       input qsnb_pkg::sq_t longest);
    qsnb_pkg::corner_t tol;
    logic pos;
    logic neg;
    tol = $signed(qsnb_pkg::CORNER_W'(longest >> qsnb_pkg::TOL_SHIFT));
    pos = 1'b0;
    neg = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (c[i] > tol)  pos = 1'b1;
      if (c[i] < -tol) neg = 1'b1;
    end
    return !(pos && neg);
  endfunction

  // orientation of (a,b,p): stored orientation of the triangle missing m,
  // negated for an odd permutation
  function automatic qsnb_pkg::corner_t corner_val(input qsnb_pkg::orv_t o [4],
      input qsnb_pkg::vidx_t a, input qsnb_pkg::vidx_t b,
      input qsnb_pkg::vidx_t p, input qsnb_pkg::vidx_t m);
    logic              odd;
    qsnb_pkg::corner_t v;
    odd = (a > b) ^ (a > p) ^ (b > p);
    v   = qsnb_pkg::CORNER_W'(o[m]);
    return odd ? -v : v;
  endfunction

  // stage 4 registers
  qsnb_pkg::sq_t   sq4 [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::orv_t  orv4 [4];
  qsnb_pkg::sq_t   longest0;
  logic            bef [qsnb_pkg::NUM_PAIRS];
  logic            bef_next [qsnb_pkg::NUM_PAIRS];

  // stage 5 registers
  qsnb_pkg::sq_t   sq5 [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::orv_t  orv5 [4];
  logic            convex0_5;
  qsnb_pkg::vidx_t ord5 [4];
  qsnb_pkg::vidx_t ord_next [4];
  logic            convex0_next;

  // stage 6 registers
  logic              convex0_6;
  qsnb_pkg::vidx_t   ord6 [4];
  qsnb_pkg::sq_t     longest1;
  qsnb_pkg::corner_t c1 [4];
  qsnb_pkg::corner_t c1_next [4];
  qsnb_pkg::sq_t     longest1_next;

  // pairwise sort relation: whether the lower-index vertex of each pair sorts first
  always_comb begin
    qsnb_pkg::vidx_t a;
    qsnb_pkg::vidx_t b;
    for (int p = 0; p < qsnb_pkg::NUM_PAIRS; p++) begin
      a = qsnb_pkg::PAIR_A[p];
      b = qsnb_pkg::PAIR_B[p];
      if (acls[a] != acls[b]) begin
        bef_next[p] = acls[a] < acls[b];
      end else if ((acls[a] == qsnb_pkg::ANG_BELOW || acls[a] == qsnb_pkg::ANG_ABOVE)
                   && cp[p] != '0) begin
        bef_next[p] = cp[p] > 0;
      end else if (dsq[a] != dsq[b]) begin
        bef_next[p] = dsq[a] < dsq[b];
      end else begin
        bef_next[p] = 1'b1;
      end
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sq4      <= sq;
      orv4     <= orv;
      bef      <= bef_next;
      longest0 <= max2(max2(sq[qsnb_pkg::pair_idx(2'd0, 2'd1)],
                            sq[qsnb_pkg::pair_idx(2'd1, 2'd2)]),
                       max2(sq[qsnb_pkg::pair_idx(2'd2, 2'd3)],
                            sq[qsnb_pkg::pair_idx(2'd3, 2'd0)]));
    end
  end

  // convexity as given and sorted order from ranks
  always_comb begin
    qsnb_pkg::corner_t c0 [4];
    qsnb_pkg::vidx_t   rank;
    logic              b;
    for (int i = 0; i < 4; i++) begin
      c0[i] = corner_val(orv4, 2'(i), 2'(i + 1), 2'(i + 2), 2'(i + 3));
    end
    convex0_next = signs_agree(c0, longest0);
    for (int v = 0; v < 4; v++) ord_next[v] = '0;
    for (int v = 0; v < 4; v++) begin
      rank = '0;
      for (int u = 0; u < 4; u++) begin
        if (u != v) begin
          b = bef[qsnb_pkg::pair_idx(2'(u), 2'(v))];
          if (u > v) b = !b;
          rank = rank + qsnb_pkg::vidx_t'(b);
        end
      end
      ord_next[rank] = 2'(v);
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en[4]) begin
      sq5       <= sq4;
      orv5      <= orv4;
      convex0_5 <= convex0_next;
      ord5      <= ord_next;
    end
  end

  // edges and corners of the sorted order
  always_comb begin
    longest1_next = '0;
    for (int i = 0; i < 4; i++) begin
      longest1_next = max2(longest1_next,
                           sq5[qsnb_pkg::pair_idx(ord5[i], ord5[(i + 1) % 4])]);
      c1_next[i] = corner_val(orv5, ord5[i], ord5[(i + 1) % 4],
                              ord5[(i + 2) % 4], ord5[(i + 3) % 4]);
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (en[5]) begin
      convex0_6 <= convex0_5;
      ord6      <= ord5;
      longest1  <= longest1_next;
      c1        <= c1_next;
    end
  end

  // stage 7: class and order
  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (convex0_6) begin
        geometry_class <= qsnb_pkg::CLS_CONVEX;
        for (int i = 0; i < 4; i++) order[i] <= 2'(i);
      end else begin
        geometry_class <= signs_agree(c1, longest1) ? qsnb_pkg::CLS_REORDERED
                                                    : qsnb_pkg::CLS_UNSUPPORTED;
        order <= ord6;
      end
    end
  end

endmodule

// ===== src/qsnb_box.sv =====
// ----------------------------------------------------------------------------
// qsnb_box
// Bounding box: min/max, floor/ceil to pixels, clamp to the clip rectangle,
// emptiness test, then delay to line up with the classifier.
// ----------------------------------------------------------------------------
module qsnb_box (
  input  logic                clk,
  input  qsnb_pkg::stage_en_t en,
  input  qsnb_pkg::coord_t    x [4],
  input  qsnb_pkg::coord_t    y [4],
  input  qsnb_pkg::clip_t     clip_left,
  input  qsnb_pkg::clip_t     clip_bottom,
  input  qsnb_pkg::clip_t     clip_right,
  input  qsnb_pkg::clip_t     clip_top,
  output qsnb_pkg::clip_t     box_left,
  output qsnb_pkg::clip_t     box_right,
  output qsnb_pkg::clip_t     box_bottom,
  output qsnb_pkg::clip_t     box_top,
  output logic                box_open
);

  localparam int DELAY = qsnb_pkg::NUM_STAGES - 3;
  localparam logic signed [qsnb_pkg::COORD_W:0] CEIL_ADD =
      (qsnb_pkg::COORD_W + 1)'((1 << qsnb_pkg::FRAC_BITS) - 1);

  typedef logic signed [qsnb_pkg::PX_W-1:0]  px_t;
  typedef logic signed [qsnb_pkg::CMP_W-1:0] cmp_t;

  function automatic cmp_t eff_clip(input qsnb_pkg::clip_t r);
    return (r > qsnb_pkg::CLIP_W'(qsnb_pkg::IMAGE_LIMIT))
           ? qsnb_pkg::CMP_W'(qsnb_pkg::IMAGE_LIMIT) : cmp_t'({1'b0, r});
  endfunction

  function automatic qsnb_pkg::clip_t clamp(input px_t v, input cmp_t lo, input cmp_t hi);
    cmp_t r;
    r = qsnb_pkg::CMP_W'(v);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[qsnb_pkg::CLIP_W-1:0];
  endfunction

  qsnb_pkg::coord_t minx, maxx, miny, maxy;
  qsnb_pkg::coord_t minx_n, maxx_n, miny_n, maxy_n;
  px_t              fx0, fx1, fy0, fy1;
  qsnb_pkg::clip_t  x0, x1, y0, y1;
  qsnb_pkg::clip_t  dl [DELAY], dr [DELAY], db [DELAY], dt [DELAY];
  logic             dv [DELAY];

  // extremes of the four vertices
  always_comb begin
    minx_n = x[0]; maxx_n = x[0];
    miny_n = y[0]; maxy_n = y[0];
    for (int i = 1; i < 4; i++) begin
      if (x[i] < minx_n) minx_n = x[i];
      if (x[i] > maxx_n) maxx_n = x[i];
      if (y[i] < miny_n) miny_n = y[i];
      if (y[i] > maxy_n) maxy_n = y[i];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: extremes
    if (en[0]) begin
      minx <= minx_n; maxx <= maxx_n;
      miny <= miny_n; maxy <= maxy_n;
    end
    // stage 2: floor and ceil to whole pixels
    if (en[1]) begin
      fx0 <= qsnb_pkg::PX_W'(minx >>> qsnb_pkg::FRAC_BITS);
      fy0 <= qsnb_pkg::PX_W'(miny >>> qsnb_pkg::FRAC_BITS);
      fx1 <= qsnb_pkg::PX_W'(((qsnb_pkg::COORD_W + 1)'(maxx) + CEIL_ADD)
                             >>> qsnb_pkg::FRAC_BITS);
      fy1 <= qsnb_pkg::PX_W'(((qsnb_pkg::COORD_W + 1)'(maxy) + CEIL_ADD)
                             >>> qsnb_pkg::FRAC_BITS);
    end
    // stage 3: clamp to the clip rectangle
    if (en[2]) begin
      x0 <= clamp(fx0, eff_clip(clip_left), eff_clip(clip_right));
      x1 <= clamp(fx1, eff_clip(clip_left), eff_clip(clip_right));
      y0 <= clamp(fy0, eff_clip(clip_bottom), eff_clip(clip_top));
      y1 <= clamp(fy1, eff_clip(clip_bottom), eff_clip(clip_top));
    end
    // stage 4 on: emptiness test, then delay line
    if (en[3]) begin
      dl[0] <= x0; dr[0] <= x1; db[0] <= y0; dt[0] <= y1;
      dv[0] <= (x0 < x1) && (y0 < y1);
    end
    for (int k = 1; k < DELAY; k++) begin
      if (en[3 + k]) begin
        dl[k] <= dl[k-1]; dr[k] <= dr[k-1];
        db[k] <= db[k-1]; dt[k] <= dt[k-1];
        dv[k] <= dv[k-1];
      end
    end
  end

  assign box_left   = dl[DELAY-1];
  assign box_right  = dr[DELAY-1];
  assign box_bottom = db[DELAY-1];
  assign box_top    = dt[DELAY-1];
  assign box_open   = dv[DELAY-1];

endmodule

// ===== src/quad_setup_normalize_and_bound.sv =====
// ----------------------------------------------------------------------------
// quad_setup_normalize_and_bound
// Quad setup: convexity check, bow-tie reorder and clipped bounding box.
// ----------------------------------------------------------------------------
// Takes one quad per clock unless in_stall is raised; its class, vertex order
// and clipped pixel box pass seven register stages (differences, products,
// sums, sort relation, ranks, sorted-order corners, class), and a stage
// holding no transaction can fill while the output is stalled. The user must
// write clip registers through the cfg port only while no transaction is in
// flight; the block does not enforce this. Values above 8192 act as 8192.
// ----------------------------------------------------------------------------
module quad_setup_normalize_and_bound (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [13:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [23:0]      ax,
  input  logic signed [23:0]      ay,
  input  logic signed [23:0]      bx,
  input  logic signed [23:0]      by_coord,
  input  logic signed [23:0]      cx,
  input  logic signed [23:0]      cy,
  input  logic signed [23:0]      dx_coord,
  input  logic signed [23:0]      dy_coord,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              geometry_class,
  output logic [1:0]              first_vertex,
  output logic [1:0]              second_vertex,
  output logic [1:0]              third_vertex,
  output logic [1:0]              fourth_vertex,
  output logic [13:0]             box_left,
  output logic [13:0]             box_right,
  output logic [13:0]             box_bottom,
  output logic [13:0]             box_top,
  output logic                    visible
);

  qsnb_pkg::clip_t     clip_left, clip_bottom, clip_right, clip_top;
  qsnb_pkg::stage_en_t en;
  qsnb_pkg::stage_en_t vld;
  qsnb_pkg::coord_t    x [4];
  qsnb_pkg::coord_t    y [4];
  qsnb_pkg::sq_t       sq   [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::orv_t      orv  [4];
  qsnb_pkg::rsum_t     cp   [qsnb_pkg::NUM_PAIRS];
  qsnb_pkg::dsq_t      dsq  [4];
  logic [1:0]          acls [4];
  qsnb_pkg::vidx_t     order [4];
  logic                box_open;

  assign x = '{ax, bx, cx, dx_coord};
  assign y = '{ay, by_coord, cy, dy_coord};

  // clip registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_bottom <= '0;
      clip_right  <= qsnb_pkg::CLIP_W'(qsnb_pkg::IMAGE_LIMIT);
      clip_top    <= qsnb_pkg::CLIP_W'(qsnb_pkg::IMAGE_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qsnb_pkg::REG_CLIP_LEFT:   clip_left   <= cfg_data;
        qsnb_pkg::REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        qsnb_pkg::REG_CLIP_RIGHT:  clip_right  <= cfg_data;
        qsnb_pkg::REG_CLIP_TOP:    clip_top    <= cfg_data;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[qsnb_pkg::NUM_STAGES-1] = !vld[qsnb_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = qsnb_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < qsnb_pkg::NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  qsnb_geom u_geom (
    .clk  (clk),
    .en   (en),
    .x    (x),
    .y    (y),
    .sq   (sq),
    .orv  (orv),
    .cp   (cp),
    .dsq  (dsq),
    .acls (acls)
  );

  qsnb_classify u_classify (
    .clk            (clk),
    .en             (en),
    .sq             (sq),
    .orv            (orv),
    .cp             (cp),
    .dsq            (dsq),
    .acls           (acls),
    .geometry_class (geometry_class),
    .order          (order)
  );

  qsnb_box u_box (
    .clk         (clk),
    .en          (en),
    .x           (x),
    .y           (y),
    .clip_left   (clip_left),
    .clip_bottom (clip_bottom),
    .clip_right  (clip_right),
    .clip_top    (clip_top),
    .box_left    (box_left),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .box_top     (box_top),
    .box_open    (box_open)
  );

  // result
  assign out_valid     = vld[qsnb_pkg::NUM_STAGES-1];
  assign first_vertex  = order[0];
  assign second_vertex = order[1];
  assign third_vertex  = order[2];
  assign fourth_vertex = order[3];
  assign visible       = box_open && (geometry_class != qsnb_pkg::CLS_UNSUPPORTED);

endmodule

// ===== src/qsnb_check.sv =====
// ----------------------------------------------------------------------------
// qsnb_check
// Port-level checks on the quad setup results.
// ----------------------------------------------------------------------------
module qsnb_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  geometry_class,
  input logic [1:0]  first_vertex,
  input logic [1:0]  second_vertex,
  input logic [1:0]  third_vertex,
  input logic [1:0]  fourth_vertex,
  input logic [13:0] box_left,
  input logic [13:0] box_right,
  input logic [13:0] box_bottom,
  input logic [13:0] box_top,
  input logic        visible
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(geometry_class)
      && $stable(first_vertex) && $stable(box_left) && $stable(visible))
    else $error("stalled result changed");

  // the order is a permutation of the four vertices
  a_perm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_vertex != second_vertex && first_vertex != third_vertex
      && first_vertex != fourth_vertex && second_vertex != third_vertex
      && second_vertex != fourth_vertex && third_vertex != fourth_vertex)
    else $error("vertex order is not a permutation");

  // convex as given keeps the input order
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && geometry_class == qsnb_pkg::CLS_CONVEX |->
      first_vertex == 2'd0 && second_vertex == 2'd1
      && third_vertex == 2'd2 && fourth_vertex == 2'd3)
    else $error("convex quad reordered");

  // visible needs a supported quad and a non-empty box
  a_vis: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> geometry_class != qsnb_pkg::CLS_UNSUPPORTED
      && box_left < box_right && box_bottom < box_top)
    else $error("visible flag without a drawable box");

endmodule

bind quad_setup_normalize_and_bound qsnb_check u_qsnb_check (.*);
